[rtl/offset_nybble_varint_packer_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the offset nybble varint packer
// Same-cycle and next-cycle implication checks under an active-low reset.
// ----------------------------------------------------------------------------
`ifndef OFFSET_NYBBLE_VARINT_PACKER_UNIT_ASSERT_SVH
`define OFFSET_NYBBLE_VARINT_PACKER_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define ONVP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check cons in the cycle after ante.
`define ONVP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/onvp_pkg.sv]
// ----------------------------------------------------------------------------
// onvp_pkg
// Shared codes, constants and queue entry type of the nybble packer.
// ----------------------------------------------------------------------------
package onvp_pkg;

	localparam int POSITION_BITS_DEF = 26;
	localparam int VEXT_BITS         = 34;
	localparam int QUEUE_DEPTH       = 4;
	localparam int QPTR_BITS         = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] ACT_RAW = 2'd0;
	localparam logic [1:0] ACT_REF = 2'd1;
	localparam logic [1:0] ACT_EOS = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO     = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_MISALIGN = 2'd3;

	localparam logic [VEXT_BITS-1:0] FORM2_MAX = VEXT_BITS'(32'h0000_00FC);
	localparam logic [VEXT_BITS-1:0] FORM4_MAX = VEXT_BITS'(32'h0000_01FC);
	localparam logic [VEXT_BITS-1:0] FORM6_MAX = VEXT_BITS'(32'h0001_01FC);
	localparam logic [VEXT_BITS-1:0] FORM8_MAX = VEXT_BITS'(32'h0101_01FC);

	localparam logic [7:0]  FORM4_BIAS = 8'hFD;
	localparam logic [15:0] FORM6_BIAS = 16'h01FD;
	localparam logic [23:0] FORM8_BIAS = 24'h0101FD;

	localparam logic [3:0] PREFIX_HI = 4'hF;
	localparam logic [3:0] PREFIX_4  = 4'hD;
	localparam logic [3:0] PREFIX_6  = 4'hE;
	localparam logic [3:0] PREFIX_8  = 4'hF;

	typedef enum logic [2:0] {
		K_RAW      = 3'd0,
		K_REF      = 3'd1,
		K_ZERO     = 3'd2,
		K_MISMATCH = 3'd3,
		K_EOS      = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [3:0]  raw;
		logic [31:0] nybs;
		logic [1:0]  last_idx;
	} entry_t;

endpackage

[rtl/onvp_front.sv]
// ----------------------------------------------------------------------------
// onvp_front
// Accepts items, folds reference distances and picks the offset form.
// ----------------------------------------------------------------------------
module onvp_front #(
	parameter int POSITION_BITS = onvp_pkg::POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic [1:0]               action,
	input  logic [3:0]               raw_nybble,
	input  logic [POSITION_BITS-1:0] source_position,
	input  logic [POSITION_BITS-1:0] target_position,
	input  logic [3:0]               ref_length,
	output logic                     push,
	output onvp_pkg::entry_t         push_entry,
	input  logic                     full
);

	localparam int EW = POSITION_BITS + 1;
	localparam int DW = POSITION_BITS + 2;

	logic                     v_s1, v_s2;
	logic [1:0]               act_s1, act_s2;
	logic [3:0]               raw_s1, raw_s2;
	logic [3:0]               len_s1, len_s2;
	logic [POSITION_BITS-1:0] dst_s1;
	logic [EW-1:0]            end_s1, end1_s1;
	logic                     zero_s2;
	logic [DW-1:0]            val_s2;

	logic                     ready1, ready2, act_ok;
	logic [DW-1:0]            diff_c, diff_a;
	logic [EW-1:0]            mag;
	logic [onvp_pkg::VEXT_BITS-1:0] vx;
	logic [7:0]               p4;
	logic [15:0]              p6;
	logic [23:0]              p8;
	logic [3:0]               nlen;
	logic [31:0]              nybs;
	logic [2:0]               half;
	logic                     mismatch;

	assign act_ok = (action == onvp_pkg::ACT_RAW) || (action == onvp_pkg::ACT_REF) ||
		(action == onvp_pkg::ACT_EOS);

	assign ready2    = !v_s2 || !full;
	assign ready1    = !v_s1 || ready2;
	assign cmd_stall = !ready1;
	assign push      = v_s2 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready1) begin
				v_s1 <= cmd_valid && act_ok;
			end
			if (ready2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready1 && cmd_valid) begin
			act_s1  <= action;
			raw_s1  <= raw_nybble;
			len_s1  <= ref_length;
			dst_s1  <= target_position;
			end_s1  <= EW'(source_position) + EW'(ref_length);
			end1_s1 <= EW'(source_position) + EW'(ref_length) + EW'(1);
		end
	end

	assign diff_c = DW'(dst_s1) - DW'(end_s1);
	assign diff_a = DW'(dst_s1) - DW'(end1_s1);
	assign mag    = diff_c[DW-1] ? ~diff_c[EW-1:0] : diff_a[EW-1:0];

	always_ff @(posedge clk) begin
		if (ready2 && v_s1) begin
			act_s2  <= act_s1;
			raw_s2  <= raw_s1;
			len_s2  <= len_s1;
			zero_s2 <= (diff_c == '0);
			val_s2  <= {mag, ~diff_c[DW-1]};
		end
	end

	assign vx = onvp_pkg::VEXT_BITS'(val_s2);
	assign p4 = vx[7:0] - onvp_pkg::FORM4_BIAS;
	assign p6 = vx[15:0] - onvp_pkg::FORM6_BIAS;
	assign p8 = vx[23:0] - onvp_pkg::FORM8_BIAS;

	always_comb begin
		if (vx <= onvp_pkg::FORM2_MAX) begin
			nlen = 4'd2;
			nybs = {24'h0, vx[3:0], vx[7:4]};
		end else if (vx <= onvp_pkg::FORM4_MAX) begin
			nlen = 4'd4;
			nybs = {16'h0, p4[3:0], p4[7:4], onvp_pkg::PREFIX_4, onvp_pkg::PREFIX_HI};
		end else if (vx <= onvp_pkg::FORM6_MAX) begin
			nlen = 4'd6;
			nybs = {8'h0, p6[3:0], p6[7:4], p6[11:8], p6[15:12],
				onvp_pkg::PREFIX_6, onvp_pkg::PREFIX_HI};
		end else if (vx <= onvp_pkg::FORM8_MAX) begin
			nlen = 4'd8;
			nybs = {p8[3:0], p8[7:4], p8[11:8], p8[15:12], p8[19:16], p8[23:20],
				onvp_pkg::PREFIX_8, onvp_pkg::PREFIX_HI};
		end else begin
			nlen = 4'd0;
			nybs = 32'h0;
		end
	end

	assign mismatch = (nlen == 4'd0) || (nlen != len_s2);
	assign half     = nlen[3:1] - 3'd1;

	always_comb begin
		push_entry.raw      = raw_s2;
		push_entry.nybs     = nybs;
		push_entry.last_idx = half[1:0];
		unique case (act_s2)
			onvp_pkg::ACT_RAW: begin
				push_entry.kind = onvp_pkg::K_RAW;
			end
			onvp_pkg::ACT_REF: begin
				if (zero_s2) begin
					push_entry.kind = onvp_pkg::K_ZERO;
				end else if (mismatch) begin
					push_entry.kind = onvp_pkg::K_MISMATCH;
				end else begin
					push_entry.kind = onvp_pkg::K_REF;
				end
			end
			default: begin
				push_entry.kind = onvp_pkg::K_EOS;
			end
		endcase
	end

endmodule

[rtl/onvp_queue.sv]
// ----------------------------------------------------------------------------
// onvp_queue
// Short FIFO of classified items between the front and back parts.
// ----------------------------------------------------------------------------
module onvp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  onvp_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output onvp_pkg::entry_t head
);

	onvp_pkg::entry_t                 mem_q [onvp_pkg::QUEUE_DEPTH];
	logic [onvp_pkg::QPTR_BITS-1:0]   wr_ptr_q, rd_ptr_q;
	logic [onvp_pkg::QPTR_BITS:0]     count_q;

	assign full       = (count_q == (onvp_pkg::QPTR_BITS+1)'(onvp_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

[rtl/onvp_back.sv]
// ----------------------------------------------------------------------------
// onvp_back
// Pairs nybbles into bytes; one beat per cycle to the output register unless stalled.
// ----------------------------------------------------------------------------
module onvp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             head_valid,
	input  onvp_pkg::entry_t head,
	output logic             pop,
	output logic             byte_valid,
	input  logic             byte_stall,
	output logic [7:0]       packed_byte,
	output logic [1:0]       status,
	output logic             last
);

	logic [3:0] pend_q;
	logic       pend_v_q;
	logic [1:0] idx_q;
	logic       out_valid_q;
	logic [7:0] byte_q;
	logic [1:0] status_q;
	logic       last_q;

	logic       out_free, emits, go, done;
	logic [7:0] nx_byte;
	logic [1:0] nx_status;
	logic       nx_last;
	logic [2:0] sel_lo, sel_hi;
	logic [3:0] nyb_lo, nyb_hi, nyb_end;

	assign out_free = !out_valid_q || !byte_stall;
	assign sel_hi   = pend_v_q ? {idx_q, 1'b0} : {idx_q, 1'b1};
	assign sel_lo   = {idx_q, 1'b0} - {2'b00, pend_v_q};
	assign nyb_hi   = head.nybs[{sel_hi, 2'b00} +: 4];
	assign nyb_lo   = (pend_v_q && idx_q == 2'd0) ? pend_q : head.nybs[{sel_lo, 2'b00} +: 4];
	assign nyb_end  = head.nybs[{head.last_idx, 1'b1, 2'b00} +: 4];

	always_comb begin
		emits     = 1'b0;
		nx_byte   = 8'h00;
		nx_status = onvp_pkg::ST_OK;
		nx_last   = 1'b1;
		unique case (head.kind)
			onvp_pkg::K_RAW: begin
				emits   = pend_v_q;
				nx_byte = {head.raw, pend_q};
			end
			onvp_pkg::K_REF: begin
				emits   = 1'b1;
				nx_byte = {nyb_hi, nyb_lo};
				nx_last = (idx_q == head.last_idx);
			end
			onvp_pkg::K_ZERO: begin
				emits     = 1'b1;
				nx_status = onvp_pkg::ST_ZERO;
			end
			onvp_pkg::K_MISMATCH: begin
				emits     = 1'b1;
				nx_status = onvp_pkg::ST_MISMATCH;
			end
			onvp_pkg::K_EOS: begin
				emits     = pend_v_q;
				nx_byte   = {4'h0, pend_q};
				nx_status = onvp_pkg::ST_MISALIGN;
			end
			default: begin
				emits = 1'b0;
			end
		endcase
	end

	assign go   = head_valid && (!emits || out_free);
	assign done = go && (head.kind != onvp_pkg::K_REF || idx_q == head.last_idx);
	assign pop  = done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 4'h0;
			pend_v_q    <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= go && emits;
			end
			if (go) begin
				idx_q <= done ? 2'd0 : idx_q + 2'd1;
				case (head.kind)
					onvp_pkg::K_RAW: begin
						pend_v_q <= !pend_v_q;
						pend_q   <= pend_v_q ? 4'h0 : head.raw;
					end
					onvp_pkg::K_REF: begin
						if (done && pend_v_q) begin
							pend_q <= nyb_end;
						end
					end
					onvp_pkg::K_EOS: begin
						pend_v_q <= 1'b0;
						pend_q   <= 4'h0;
					end
					default: begin
						pend_v_q <= pend_v_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && emits) begin
			byte_q   <= nx_byte;
			status_q <= nx_status;
			last_q   <= nx_last;
		end
	end

	assign byte_valid  = out_valid_q;
	assign packed_byte = byte_q;
	assign status      = status_q;
	assign last        = last_q;

endmodule

[rtl/offset_nybble_varint_packer_unit.sv]
// ----------------------------------------------------------------------------
// offset_nybble_varint_packer_unit
// Packs command nybbles and variable-length relative offsets into bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the cmd channel (cmd_valid / cmd_stall): a raw nybble, a
//   reference with source, target and chosen length, or end of stream.
//   Bytes leave on the byte channel (byte_valid / byte_stall) with a status
//   and a last flag on the final beat caused by an item.
//   An accepted item passes front stages s1 and s2 and the queue; its first
//   beat is then registered at the output. The front takes one item per
//   cycle unless stalled; the back sends one beat per cycle unless stalled,
//   n/2 beats for an n-nybble reference. The byte port sets the sustained rate.
//   A four-entry queue between front and back absorbs bursts; when it is full
//   the front stages fill and the front holds cmd_stall high.
//   While byte_stall is high the output beat holds and the back waits; the
//   front keeps accepting until the queue and front stages fill.
//   Reset (arst_n low) empties the pipeline and queue and drops any held
//   nybble.
// ----------------------------------------------------------------------------
module offset_nybble_varint_packer_unit #(
	parameter int POSITION_BITS = onvp_pkg::POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  logic [1:0]               action,
	input  logic [3:0]               raw_nybble,
	input  logic [POSITION_BITS-1:0] source_position,
	input  logic [POSITION_BITS-1:0] target_position,
	input  logic [3:0]               ref_length,
	output logic                     byte_valid,
	input  logic                     byte_stall,
	output logic [7:0]               packed_byte,
	output logic [1:0]               status,
	output logic                     last
);

	logic             push, full, pop, head_valid;
	onvp_pkg::entry_t push_entry, head;

	onvp_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_stall      (cmd_stall),
		.action         (action),
		.raw_nybble     (raw_nybble),
		.source_position(source_position),
		.target_position(target_position),
		.ref_length     (ref_length),
		.push           (push),
		.push_entry     (push_entry),
		.full           (full)
	);

	onvp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.full      (full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	onvp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.packed_byte(packed_byte),
		.status     (status),
		.last       (last)
	);

endmodule

[rtl/onvp_checker.sv]
// ----------------------------------------------------------------------------
// onvp_checker
// Port-level checks on the byte channel of the packer, bound to the top level.
// ----------------------------------------------------------------------------
`include "offset_nybble_varint_packer_unit_assert.svh"

module onvp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       byte_valid,
	input logic       byte_stall,
	input logic [7:0] packed_byte,
	input logic [1:0] status,
	input logic       last
);

	`ONVP_ASSERT_NXT(a_beat_hold, clk, arst_n, byte_valid && byte_stall, byte_valid && $stable(packed_byte) && $stable(status) && $stable(last), "stalled beat changed")

	`ONVP_ASSERT_IMP(a_err_last, clk, arst_n, byte_valid && status != onvp_pkg::ST_OK, last, "error beat without last")

	`ONVP_ASSERT_IMP(a_err_zero, clk, arst_n, byte_valid && (status == onvp_pkg::ST_ZERO || status == onvp_pkg::ST_MISMATCH), packed_byte == 8'h00, "error beat carries data")

	`ONVP_ASSERT_IMP(a_misalign_hi, clk, arst_n, byte_valid && status == onvp_pkg::ST_MISALIGN, packed_byte[7:4] == 4'h0, "misaligned end beat has high nybble")

endmodule

bind offset_nybble_varint_packer_unit onvp_checker u_onvp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.byte_valid (byte_valid),
	.byte_stall (byte_stall),
	.packed_byte(packed_byte),
	.status     (status),
	.last       (last)
);

[tb/sv/onvp_stream_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onvp_stream_checker
// Watches the cmd and byte channels of the nybble packer. Folds every
// accepted item into the expected byte stream (pairing, offset encoding,
// status codes) and compares each byte beat against the oldest owed byte.
// ----------------------------------------------------------------------------
module onvp_stream_checker #(
	parameter int POSITION_BITS = onvp_pkg::POSITION_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	input  logic                     cmd_stall,
	input  logic [1:0]               action,
	input  logic [3:0]               raw_nybble,
	input  logic [POSITION_BITS-1:0] source_position,
	input  logic [POSITION_BITS-1:0] target_position,
	input  logic [3:0]               ref_length,
	input  logic                     byte_valid,
	input  logic                     byte_stall,
	input  logic [7:0]               packed_byte,
	input  logic [1:0]               status,
	input  logic                     last,
	output int                       failures,
	output int                       backlog
);
	import onvp_pkg::*;

	typedef struct {
		logic [7:0] octet;
		logic [1:0] code;
		logic       tail;
	} owed_byte_t;

	owed_byte_t owed_bytes[$];
	logic [3:0] held_nybble;
	logic       held_valid;

	function automatic void owe_byte(logic [7:0] octet, logic [1:0] code, logic tail);
		owed_byte_t entry;
		entry.octet = octet;
		entry.code  = code;
		entry.tail  = tail;
		owed_bytes.push_back(entry);
	endfunction

	function automatic void encode_jump(logic [POSITION_BITS-1:0] src,
		logic [POSITION_BITS-1:0] dst, logic [3:0] len);
		logic [39:0] far_end;
		logic [39:0] mag;
		logic [39:0] folded;
		logic [39:0] payload;
		logic [3:0]  nybs [8];
		int          count;
		far_end = 40'(src) + 40'(len);
		if (40'(dst) == far_end) begin
			owe_byte(8'h00, ST_ZERO, 1'b1);
			return;
		end
		if (40'(dst) < far_end)
			mag = (far_end - 40'(dst)) << 1;
		else
			mag = ((40'(dst) - far_end) << 1) | 40'd1;
		folded = mag - 40'd2;
		count = 0;
		if (folded <= 40'(FORM2_MAX)) begin
			count = 2;
			nybs[0] = folded[7:4];
			nybs[1] = folded[3:0];
		end else if (folded <= 40'(FORM4_MAX)) begin
			count = 4;
			payload = folded - 40'(FORM4_BIAS);
			nybs[0] = PREFIX_HI;
			nybs[1] = PREFIX_4;
			for (int i = 0; i < 2; i++)
				nybs[2 + i] = payload[4 * (1 - i) +: 4];
		end else if (folded <= 40'(FORM6_MAX)) begin
			count = 6;
			payload = folded - 40'(FORM6_BIAS);
			nybs[0] = PREFIX_HI;
			nybs[1] = PREFIX_6;
			for (int i = 0; i < 4; i++)
				nybs[2 + i] = payload[4 * (3 - i) +: 4];
		end else if (folded <= 40'(FORM8_MAX)) begin
			count = 8;
			payload = folded - 40'(FORM8_BIAS);
			nybs[0] = PREFIX_HI;
			nybs[1] = PREFIX_8;
			for (int i = 0; i < 6; i++)
				nybs[2 + i] = payload[4 * (5 - i) +: 4];
		end
		if (count == 0 || count != int'(len)) begin
			owe_byte(8'h00, ST_MISMATCH, 1'b1);
			return;
		end
		for (int i = 0; i < count; i++) begin
			if (held_valid) begin
				owe_byte({nybs[i], held_nybble}, ST_OK, 1'b0);
				held_valid  = 1'b0;
				held_nybble = 4'h0;
			end else begin
				held_nybble = nybs[i];
				held_valid  = 1'b1;
			end
		end
		owed_bytes[owed_bytes.size() - 1].tail = 1'b1;
	endfunction

	function automatic void absorb_item();
		case (action)
			ACT_RAW: begin
				if (held_valid) begin
					owe_byte({raw_nybble, held_nybble}, ST_OK, 1'b1);
					held_valid  = 1'b0;
					held_nybble = 4'h0;
				end else begin
					held_nybble = raw_nybble;
					held_valid  = 1'b1;
				end
			end
			ACT_REF: begin
				encode_jump(source_position, target_position, ref_length);
			end
			ACT_EOS: begin
				if (held_valid) begin
					owe_byte({4'h0, held_nybble}, ST_MISALIGN, 1'b1);
					held_valid  = 1'b0;
					held_nybble = 4'h0;
				end
			end
			default: begin
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		int bad;
		owed_byte_t want;
		bad = 0;
		if (!arst_n) begin
			owed_bytes.delete();
			held_nybble = 4'h0;
			held_valid  = 1'b0;
			failures <= 0;
			backlog  <= 0;
		end else begin
			if (byte_valid && !byte_stall) begin
				if (owed_bytes.size() == 0) begin
					$error("unexpected beat: packed_byte %0h status %0d last %0d",
						packed_byte, status, last);
					bad++;
				end else begin
					want = owed_bytes.pop_front();
					if (packed_byte !== want.octet) begin
						$error("packed_byte expected %0h actual %0h", want.octet, packed_byte);
						bad++;
					end
					if (status !== want.code) begin
						$error("status expected %0d actual %0d", want.code, status);
						bad++;
					end
					if (last !== want.tail) begin
						$error("last expected %0d actual %0d", want.tail, last);
						bad++;
					end
				end
			end
			if (cmd_valid && !cmd_stall)
				absorb_item();
			failures <= failures + bad;
			backlog  <= owed_bytes.size();
		end
	end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the offset nybble varint packer: directed edge
// cases of the offset forms, then random well-formed references, raw
// nybbles and broken items under random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
	import onvp_pkg::*;

	localparam int              PB            = POSITION_BITS_DEF;
	localparam longint unsigned SPAN          = 64'd1 << PB;
	localparam logic [1:0]      ACT_SPARE     = 2'd3;
	localparam int              RANDOM_ITEMS  = 480;
	localparam int              CYCLE_LIMIT   = 200000;
	localparam int              SETTLE_CYCLES = 16;

	logic          clk;
	logic          arst_n;
	logic          cmd_valid;
	logic          cmd_stall;
	logic [1:0]    action;
	logic [3:0]    raw_nybble;
	logic [PB-1:0] source_position;
	logic [PB-1:0] target_position;
	logic [3:0]    ref_length;
	logic          byte_valid;
	logic          byte_stall;
	logic [7:0]    packed_byte;
	logic [1:0]    status;
	logic          last;
	int            failures;
	int            backlog;
	logic          quiet;

	offset_nybble_varint_packer_unit #(.POSITION_BITS(PB)) dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.action(action), .raw_nybble(raw_nybble),
		.source_position(source_position), .target_position(target_position),
		.ref_length(ref_length),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.packed_byte(packed_byte), .status(status), .last(last)
	);

	onvp_stream_checker #(.POSITION_BITS(PB)) u_stream_checker (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
		.action(action), .raw_nybble(raw_nybble),
		.source_position(source_position), .target_position(target_position),
		.ref_length(ref_length),
		.byte_valid(byte_valid), .byte_stall(byte_stall),
		.packed_byte(packed_byte), .status(status), .last(last),
		.failures(failures), .backlog(backlog)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : byte_sink
		int hold;
		byte_stall = 1'b0;
		forever begin
			hold = quiet ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				byte_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			byte_stall <= 1'b0;
			do @(posedge clk); while (!byte_valid);
		end
	end

	function automatic longint unsigned random_position();
		return longint'($urandom_range(0, 32'(SPAN - 1)));
	endfunction

	function automatic longint unsigned random_folded(int slot);
		longint unsigned lo;
		longint unsigned hi;
		int              pick;
		case (slot)
			0:       begin lo = 0;          hi = FORM2_MAX; end
			1:       begin lo = FORM4_BIAS; hi = FORM4_MAX; end
			2:       begin lo = FORM6_BIAS; hi = FORM6_MAX; end
			default: begin lo = FORM8_BIAS; hi = FORM8_MAX; end
		endcase
		pick = $urandom_range(0, 9);
		if (pick == 0)
			return lo;
		if (pick == 1)
			return hi;
		return lo + $urandom_range(0, 32'(hi - lo));
	endfunction

	task automatic send_item(logic [1:0] act, logic [3:0] nyb, longint unsigned src,
		longint unsigned dst, logic [3:0] len);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid       <= 1'b1;
		action          <= act;
		raw_nybble      <= nyb;
		source_position <= PB'(src);
		target_position <= PB'(dst);
		ref_length      <= len;
		do @(posedge clk); while (cmd_stall);
	endtask

	task automatic send_raw(logic [3:0] nyb);
		send_item(ACT_RAW, nyb, random_position(), random_position(), 4'($urandom));
	endtask

	task automatic send_mark(logic [1:0] act);
		send_item(act, 4'($urandom), random_position(), random_position(), 4'($urandom));
	endtask

	// place a reference so that its folded offset is exactly the given value
	task automatic send_jump(int unsigned len, longint unsigned folded);
		longint unsigned mag;
		longint unsigned distance;
		longint unsigned top;
		longint unsigned src;
		longint unsigned dst;
		mag      = folded + 2;
		distance = mag >> 1;
		top      = SPAN - 1 - len;
		if (mag[0]) begin
			src = $urandom_range(0, 32'(top - distance));
			dst = src + len + distance;
		end else begin
			src = $urandom_range(distance > len ? 32'(distance - len) : 0, 32'(top));
			dst = src + len - distance;
		end
		send_item(ACT_REF, 4'($urandom), src, dst, 4'(len));
	endtask

	task automatic send_zero(int unsigned len);
		longint unsigned src;
		src = $urandom_range(0, 32'(SPAN - 16));
		send_item(ACT_REF, 4'($urandom), src, src + len, 4'(len));
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (backlog != 0) @(posedge clk);
	endtask

	initial begin : stimulus
		int          pick;
		int          slot;
		int unsigned len;
		arst_n          = 1'b0;
		cmd_valid       = 1'b0;
		action          = ACT_RAW;
		raw_nybble      = 4'h0;
		source_position = '0;
		target_position = '0;
		ref_length      = 4'h0;
		quiet           = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_raw(4'h0);
		send_raw(4'hF);
		send_raw(4'hA);
		send_mark(ACT_EOS);
		send_mark(ACT_EOS);
		send_item(ACT_SPARE, 4'hF, SPAN - 1, SPAN - 1, 4'hF);
		send_jump(2, 0);
		send_jump(2, FORM2_MAX);
		send_raw(4'h5);
		send_jump(4, FORM4_BIAS);
		send_jump(4, FORM4_MAX);
		send_jump(6, FORM6_BIAS);
		send_jump(6, FORM6_MAX);
		send_jump(8, FORM8_BIAS);
		send_jump(8, FORM8_MAX);
		send_jump(8, FORM8_MAX + 1);
		send_jump(4, 0);
		send_jump(3, FORM2_MAX);
		send_jump(15, FORM8_MAX);
		send_zero(2);
		send_zero(0);
		// end of reference past the top of the position range
		send_item(ACT_REF, 4'h3, SPAN - 1, SPAN - 1, 4'd2);
		send_item(ACT_REF, 4'hC, 0, SPAN - 1, 4'd8);
		send_mark(ACT_EOS);
		wait_drained();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			if (i % 160 == 159)
				wait_drained();
			pick = $urandom_range(0, 99);
			slot = $urandom_range(0, 3);
			if (pick < 45) begin
				send_raw(4'($urandom));
			end else if (pick < 75) begin
				send_jump(2 * (slot + 1), random_folded(slot));
			end else if (pick < 80) begin
				send_zero($urandom_range(0, 15));
			end else if (pick < 87) begin
				do len = $urandom_range(0, 15); while (len == 2 * (slot + 1));
				send_jump(len, random_folded(slot));
			end else if (pick < 92) begin
				send_mark(ACT_EOS);
			end else if (pick < 95) begin
				send_mark(ACT_SPARE);
			end else begin
				send_item(ACT_REF, 4'($urandom), random_position(), random_position(),
					4'($urandom));
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0 && backlog == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sim.f]
+incdir+rtl
rtl/onvp_pkg.sv
rtl/onvp_front.sv
rtl/onvp_queue.sv
rtl/onvp_back.sv
rtl/offset_nybble_varint_packer_unit.sv
rtl/onvp_checker.sv
tb/sv/onvp_stream_checker.sv
tb/sv/tb.sv
